// File: src/sdrs_pkg.sv
// Shared widths, limits and register addresses for the SCAN disk request scheduler.
package sdrs_pkg;
  localparam int unsigned SEEK_W = 18;
  localparam logic [SEEK_W-1:0] SEEK_MAX = '1;
  localparam logic [0:0] REG_START_HEAD = 1'b0;
  localparam logic [0:0] REG_TOP_CYLINDER = 1'b1;
endpackage

// File: src/scan_disk_request_scheduler_core.sv
// SCAN disk request scheduler: sorted request store, sweep sequencer and output register.
// Requests of a batch are kept in ascending order in one RAM by insertion, and the batch is
// served in SCAN order once a request carries the final mark or the store fills. A request
// is taken only while the block is idle: after a transfer, in_ready_o stays low while the
// insertion steps down past each stored request greater than the new one. When the batch
// closes, the split point at the head is found by scanning the entries from the lowest up to
// and including the first entry at or above the head. Each served request then passes
// through a read, an update and an output state, and between the two sweeps a turn state
// adds the travel to the far end of the disk. The last result follows an 18-step serial
// divide of the total seek by the request count. A result waits in the output register
// while out_ready_i is low, and the sequencer waits with it.
module scan_disk_request_scheduler_core #(
  parameter int unsigned MAX_REQUESTS = 64,
  parameter int unsigned CYL_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [CYL_BITS-1:0]         request_cylinder_i,
  input  logic                        final_request_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [CYL_BITS-1:0]         served_cylinder_o,
  output logic [sdrs_pkg::SEEK_W-1:0] running_seek_o,
  output logic [sdrs_pkg::SEEK_W-1:0] average_seek_o,
  output logic                        upward_first_o,
  output logic                        end_of_order_o
);
  localparam int unsigned AW = $clog2(MAX_REQUESTS);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned SW = sdrs_pkg::SEEK_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_CLOSE, S_SPL_RD, S_SPL_CMP,
    S_SRV_RD, S_SRV_UPD, S_OUT, S_TURN, S_DIV
  } state_e;

  state_e state_q;
  logic [CYL_BITS-1:0] start_head_q, top_cyl_q, head_q, cyl_q, prev_q;
  logic [SW-1:0] seek_q;
  logic [CW-1:0] count_q, idx_q, lo_q, count_inc;
  logic fin_q, up_q, second_q;
  logic [CYL_BITS-1:0] rdata, wdata, turn_cyl;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic div_start, div_done;
  logic [SW-1:0] div_quo;
  logic ascending, sweep_end, second_exists, last_item, out_free, load_out;
  logic out_valid_q;
  logic [CYL_BITS-1:0] out_cyl_q;
  logic [SW-1:0] out_seek_q, out_avg_q;
  logic out_up_q, out_end_q;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                            input logic [CYL_BITS-1:0] a,
                                            input logic [CYL_BITS-1:0] b);
    logic [CYL_BITS-1:0] d;
    logic [CYL_BITS+SW:0] t;
    d = (a > b) ? a - b : b - a;
    t = (CYL_BITS+SW+1)'(s) + (CYL_BITS+SW+1)'(d);
    return (t > (CYL_BITS+SW+1)'(sdrs_pkg::SEEK_MAX)) ? sdrs_pkg::SEEK_MAX : SW'(t);
  endfunction

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      sdrs_pkg::REG_START_HEAD: prdata = 32'(start_head_q);
      sdrs_pkg::REG_TOP_CYLINDER: prdata = 32'(top_cyl_q);
      default: prdata = '0;
    endcase
  end

  sdrs_ram #(.WIDTH(CYL_BITS), .DEPTH(MAX_REQUESTS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  sdrs_div #(.CW(CW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(seek_q), .den_i(count_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign count_inc = count_q + CW'(1);
  assign ascending = up_q ^ second_q;
  assign sweep_end = ascending ? (idx_q == count_q - CW'(1)) : (idx_q == '0);
  assign second_exists = up_q ? (lo_q != '0) : (lo_q != count_q);
  assign last_item = sweep_end && (second_q || !second_exists);
  assign out_free = !out_valid_q || out_ready_i;
  assign div_start = (state_q == S_OUT) && last_item && out_free;
  assign load_out = ((state_q == S_OUT) && !last_item && out_free) ||
                    ((state_q == S_DIV) && div_done);
  assign turn_cyl = up_q ? top_cyl_q : '0;

  always_comb begin
    we = 1'b0;
    waddr = AW'(idx_q);
    wdata = cyl_q;
    raddr = AW'(idx_q);
    case (state_q)
      S_INS_RD: begin
        raddr = AW'(idx_q - CW'(1));
        we = (idx_q == '0);
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rdata > cyl_q) begin
          wdata = rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_head_q <= '0;
      top_cyl_q <= CYL_BITS'(199);
      head_q <= '0;
      cyl_q <= '0;
      prev_q <= '0;
      seek_q <= '0;
      count_q <= '0;
      idx_q <= '0;
      lo_q <= '0;
      fin_q <= 1'b0;
      up_q <= 1'b0;
      second_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_cyl_q <= '0;
      out_seek_q <= '0;
      out_avg_q <= '0;
      out_up_q <= 1'b0;
      out_end_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          sdrs_pkg::REG_START_HEAD: start_head_q <= pwdata[CYL_BITS-1:0];
          sdrs_pkg::REG_TOP_CYLINDER: top_cyl_q <= pwdata[CYL_BITS-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_cyl_q <= head_q;
        out_seek_q <= seek_q;
        out_up_q <= up_q;
        out_avg_q <= (state_q == S_DIV) ? div_quo : '0;
        out_end_q <= (state_q == S_DIV);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cyl_q <= request_cylinder_i;
            fin_q <= final_request_i;
            idx_q <= count_q;
            if (count_q == '0) begin
              head_q <= start_head_q;
              seek_q <= '0;
            end
            state_q <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (idx_q == '0) begin
            state_q <= S_CLOSE;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rdata > cyl_q) begin
            idx_q <= idx_q - CW'(1);
            state_q <= S_INS_RD;
          end else begin
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          count_q <= count_inc;
          idx_q <= '0;
          second_q <= 1'b0;
          if (!fin_q && count_inc < CW'(MAX_REQUESTS)) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SPL_RD;
          end
        end
        S_SPL_RD: state_q <= S_SPL_CMP;
        S_SPL_CMP: begin
          if (rdata < head_q) begin
            prev_q <= rdata;
            if (idx_q == count_q - CW'(1)) begin
              lo_q <= count_q;
              up_q <= 1'b0;
              state_q <= S_SRV_RD;
            end else begin
              idx_q <= idx_q + CW'(1);
              state_q <= S_SPL_RD;
            end
          end else begin
            lo_q <= idx_q;
            if (idx_q == '0 || (head_q - prev_q) >= (rdata - head_q)) begin
              up_q <= 1'b1;
            end else begin
              up_q <= 1'b0;
              idx_q <= idx_q - CW'(1);
            end
            state_q <= S_SRV_RD;
          end
        end
        S_SRV_RD: state_q <= S_SRV_UPD;
        S_SRV_UPD: begin
          seek_q <= sat_add(seek_q, head_q, rdata);
          head_q <= rdata;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (last_item) begin
              state_q <= S_DIV;
            end else if (sweep_end) begin
              state_q <= S_TURN;
            end else begin
              idx_q <= ascending ? idx_q + CW'(1) : idx_q - CW'(1);
              state_q <= S_SRV_RD;
            end
          end
        end
        S_TURN: begin
          seek_q <= sat_add(seek_q, head_q, turn_cyl);
          head_q <= turn_cyl;
          second_q <= 1'b1;
          idx_q <= up_q ? lo_q - CW'(1) : lo_q;
          state_q <= S_SRV_RD;
        end
        S_DIV: begin
          if (div_done) begin
            count_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign served_cylinder_o = out_cyl_q;
  assign running_seek_o = out_seek_q;
  assign average_seek_o = out_avg_q;
  assign upward_first_o = out_up_q;
  assign end_of_order_o = out_end_q;
  assign out_valid_o = out_valid_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_cyl_q) &&
    $stable(out_seek_q) && $stable(out_avg_q) && $stable(out_end_q));
  a_in_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o);
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_REQUESTS));
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV);
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_INS_RD || state_q == S_INS_CMP));
endmodule

// File: src/sdrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sdrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/sdrs_div.sv
// Restoring divider for the average seek, one quotient bit per cycle.
module sdrs_div #(
  parameter int unsigned CW = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sdrs_pkg::SEEK_W-1:0] num_i,
  input  logic [CW-1:0]             den_i,
  output logic                      done_o,
  output logic [sdrs_pkg::SEEK_W-1:0] quo_o
);
  localparam int unsigned W = sdrs_pkg::SEEK_W;
  localparam int unsigned BW = $clog2(W + 1);
  logic [W-1:0] quo_q, quo_d;
  logic [CW:0] rem_q, rem_d;
  logic [CW-1:0] den_q;
  logic [BW-1:0] cnt_q;
  logic busy_q;
  logic [CW:0] shifted;

  always_comb begin
    shifted = {rem_q[CW-1:0], quo_q[W-1]};
    quo_d = {quo_q[W-2:0], 1'b0};
    rem_d = shifted;
    if (shifted >= {1'b0, den_q}) begin
      rem_d = shifted - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= BW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == BW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = quo_q;
endmodule

// File: dv/tb.sv
// Testbench for the SCAN disk request scheduler core: directed table, random batches, predictor.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned SW = sdrs_pkg::SEEK_W;

  typedef struct packed {
    logic [15:0] cyl;
    logic        fin;
  } req_t;

  typedef struct packed {
    logic [15:0]   served;
    logic [SW-1:0] seek;
    logic [SW-1:0] avg;
    logic          up;
    logic          eoo;
  } serve_t;

  typedef struct {
    req_t   req;
    logic   chk;
    serve_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] request_cylinder_i = '0;
  logic final_request_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] served_cylinder_o;
  logic [SW-1:0] running_seek_o, average_seek_o;
  logic upward_first_o, end_of_order_o;

  always #5 clk_i = ~clk_i;

  scan_disk_request_scheduler_core DUT (.*);

  logic [15:0] sorted_reqs[64];
  int unsigned pend_count;
  logic [15:0] head_pos, cfg_head, cfg_top;
  logic [SW-1:0] seek_sum;
  serve_t served_queue[$];
  serve_t typed_queue[$];
  logic   typed_flag[$];
  int errors = 0;
  int send_idle = 7, recv_idle = 63;
  bit recv_hold = 0;
  int quiet = 0;

  task automatic travel(input logic [15:0] tgt);
    int unsigned d;
    int unsigned t;
    d = (tgt > head_pos) ? tgt - head_pos : head_pos - tgt;
    t = seek_sum + d;
    seek_sum = (t > sdrs_pkg::SEEK_MAX) ? sdrs_pkg::SEEK_MAX : SW'(t);
    head_pos = tgt;
  endtask

  task automatic serve(input logic up);
    serve_t s;
    s.served = head_pos; s.seek = seek_sum; s.avg = '0; s.up = up; s.eoo = 1'b0;
    served_queue.push_back(s);
  endtask

  task automatic schedule(input req_t r);
    int unsigned i, lo, dl, du;
    logic up;
    serve_t s;
    if (pend_count == 0) begin
      head_pos = cfg_head;
      seek_sum = '0;
    end
    i = pend_count;
    while (i > 0 && sorted_reqs[i-1] > r.cyl) begin
      sorted_reqs[i] = sorted_reqs[i-1];
      i--;
    end
    sorted_reqs[i] = r.cyl;
    pend_count++;
    if (!r.fin && pend_count < 64) return;
    lo = 0;
    while (lo < pend_count && sorted_reqs[lo] < head_pos) lo++;
    if (lo == 0) up = 1'b1;
    else if (lo == pend_count) up = 1'b0;
    else begin
      dl = head_pos - sorted_reqs[lo-1];
      du = sorted_reqs[lo] - head_pos;
      up = (dl < du) ? 1'b0 : 1'b1;
    end
    if (up) begin
      for (i = lo; i < pend_count; i++) begin travel(sorted_reqs[i]); serve(up); end
      if (lo > 0) begin
        travel(cfg_top);
        for (i = lo; i > 0; i--) begin travel(sorted_reqs[i-1]); serve(up); end
      end
    end else begin
      for (i = lo; i > 0; i--) begin travel(sorted_reqs[i-1]); serve(up); end
      if (lo < pend_count) begin
        travel(16'd0);
        for (i = lo; i < pend_count; i++) begin travel(sorted_reqs[i]); serve(up); end
      end
    end
    s = served_queue.pop_back();
    s.avg = SW'(seek_sum / pend_count);
    s.eoo = 1'b1;
    served_queue.push_back(s);
    pend_count = 0;
  endtask

  task automatic reg_write(input logic reg_sel, input logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00}; pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == sdrs_pkg::REG_START_HEAD) cfg_head = val;
    else cfg_top = val;
  endtask

  task automatic drain();
    while (served_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send(input req_t r, input logic chk, input serve_t want);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    in_valid_i <= 1'b1;
    request_cylinder_i <= r.cyl;
    final_request_i <= r.fin;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    if (chk) begin
      typed_queue.push_back(want);
      typed_flag.push_back(1'b1);
    end
    schedule(r);
  endtask

  function automatic logic [15:0] rand_cyl(input int mode);
    case (mode)
      0: return 16'($urandom_range(65535));
      1: return 16'(cfg_top - $urandom_range(cfg_top < 20 ? cfg_top : 20));
      default: return 16'($urandom_range(cfg_top > 300 ? 300 : cfg_top));
    endcase
  endfunction

  always @(posedge clk_i) begin
    serve_t exp_s;
    if (out_valid_o && out_ready_i) begin
      if (served_queue.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_s = served_queue.pop_front();
        if (typed_queue.size() != 0 && exp_s.eoo) begin
          if (typed_queue[0] != exp_s) begin
            $error("typed row disagrees: expected %h, predicted %h", typed_queue[0], exp_s);
            errors++;
          end
          void'(typed_queue.pop_front());
          void'(typed_flag.pop_front());
        end
        if (served_cylinder_o !== exp_s.served) begin
          $error("served_cylinder expected %0d actual %0d", exp_s.served, served_cylinder_o);
          errors++;
        end
        if (running_seek_o !== exp_s.seek) begin
          $error("running_seek expected %0d actual %0d", exp_s.seek, running_seek_o);
          errors++;
        end
        if (average_seek_o !== exp_s.avg) begin
          $error("average_seek expected %0d actual %0d", exp_s.avg, average_seek_o);
          errors++;
        end
        if (upward_first_o !== exp_s.up) begin
          $error("upward_first expected %0d actual %0d", exp_s.up, upward_first_o);
          errors++;
        end
        if (end_of_order_o !== exp_s.eoo) begin
          $error("end_of_order expected %0d actual %0d", exp_s.eoo, end_of_order_o);
          errors++;
        end
      end
    end
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("** scan_disk_request_scheduler_core: FAILED **");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    serve_t none, w;
    int n, len, mode;
    req_t r;
    none = '0;
    pend_count = 0; seek_sum = '0; cfg_head = 16'd0; cfg_top = 16'd199; head_pos = 16'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: single requests with known results, then special batches.
    w = '{served: 16'd0, seek: 0, avg: 0, up: 1'b1, eoo: 1'b1};
    rows.push_back('{'{16'd0, 1'b1}, 1'b1, w});
    w = '{served: 16'hFFFF, seek: 18'd65535, avg: 18'd65535, up: 1'b1, eoo: 1'b1};
    rows.push_back('{'{16'hFFFF, 1'b1}, 1'b1, w});
    rows.push_back('{'{16'd50, 1'b0}, 1'b0, none});
    rows.push_back('{'{16'd10, 1'b0}, 1'b0, none});
    rows.push_back('{'{16'd10, 1'b0}, 1'b0, none});
    rows.push_back('{'{16'd150, 1'b1}, 1'b0, none});
    rows.push_back('{'{16'hFFFF, 1'b0}, 1'b0, none});
    rows.push_back('{'{16'h5555, 1'b0}, 1'b0, none});
    rows.push_back('{'{16'hAAAA, 1'b1}, 1'b0, none});
    foreach (rows[k]) send(rows[k].req, rows[k].chk, rows[k].want);
    drain();
    reg_write(sdrs_pkg::REG_START_HEAD, 16'd100);
    reg_write(sdrs_pkg::REG_TOP_CYLINDER, 16'd120);
    send('{16'd90, 1'b0}, 1'b0, none);
    send('{16'd110, 1'b0}, 1'b0, none);
    send('{16'd500, 1'b0}, 1'b0, none);
    send('{16'd100, 1'b1}, 1'b0, none);
    send('{16'd20, 1'b0}, 1'b0, none);
    send('{16'd99, 1'b1}, 1'b0, none);
    drain();
    reg_write(sdrs_pkg::REG_START_HEAD, 16'hFFFF);
    reg_write(sdrs_pkg::REG_TOP_CYLINDER, 16'hFFFF);
    send('{16'd0, 1'b0}, 1'b0, none);
    send('{16'hFFFE, 1'b1}, 1'b0, none);
    // Store full with far seeks.
    for (int k = 0; k < 64; k++) send('{(k % 2) ? 16'hFFFF : 16'd0, 1'b0}, 1'b0, none);
    // Long receiver hold while the sender keeps going.
    recv_hold = 1;
    fork
      begin repeat (3000) @(posedge clk_i); recv_hold = 0; end
      for (int k = 0; k < 40; k++)
        send('{16'($urandom_range(65535)), (k == 39) || ($urandom_range(7) == 0)}, 1'b0, none);
    join
    drain();

    n = 0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 63; recv_idle = 7; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      reg_write(sdrs_pkg::REG_START_HEAD, ph == 2 ? 16'd0 : 16'($urandom_range(65535)));
      reg_write(sdrs_pkg::REG_TOP_CYLINDER,
                ph == 0 ? 16'd1 : (ph == 1 ? 16'hFFFF : 16'd199));
      if (ph == 0) reg_write(sdrs_pkg::REG_TOP_CYLINDER, 16'($urandom_range(1, 65535)));
      while (n < 100 * (ph + 1)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
        mode = $urandom_range(2);
        for (int k = 0; k < len; k++) begin
          r.cyl = rand_cyl(mode);
          r.fin = (k == len - 1) || ($urandom_range(19) == 0);
          if (k == 0 && $urandom_range(3) == 0) begin
            drain();
            reg_write(sdrs_pkg::REG_START_HEAD, head_pos);
          end
          send(r, 1'b0, none);
          n++;
        end
        if (r.fin == 1'b0) send('{16'($urandom_range(65535)), 1'b1}, 1'b0, none);
        if ($urandom_range(15) == 0) begin
          drain();
          reg_write(sdrs_pkg::REG_START_HEAD, 16'($urandom_range(65535)));
        end
      end
      drain();
    end

    if (errors == 0 && served_queue.size() == 0)
      $display("** scan_disk_request_scheduler_core: PASSED **");
    else
      $display("** scan_disk_request_scheduler_core: FAILED **");
    $finish;
  end
endmodule
